[design/wphg_pkg.sv]
// Package for the PLCP header generator: rate codes, signal codes and stage types.
// Used by every module of the block; depends on nothing else.
package wphg_pkg;

    // Rate codes in 500 kbit/s units
    localparam logic [7:0] RATE_OFDM_6   = 8'd12;
    localparam logic [7:0] RATE_OFDM_9   = 8'd18;
    localparam logic [7:0] RATE_OFDM_12  = 8'd24;
    localparam logic [7:0] RATE_OFDM_18  = 8'd36;
    localparam logic [7:0] RATE_OFDM_24  = 8'd48;
    localparam logic [7:0] RATE_OFDM_36  = 8'd72;
    localparam logic [7:0] RATE_OFDM_48  = 8'd96;
    localparam logic [7:0] RATE_OFDM_54  = 8'd108;
    localparam logic [7:0] RATE_CCK_1    = 8'd2;
    localparam logic [7:0] RATE_CCK_2    = 8'd4;
    localparam logic [7:0] RATE_CCK_5M5  = 8'd11;
    localparam logic [7:0] RATE_CCK_11   = 8'd22;

    // OFDM SIGNAL rate nibbles
    localparam logic [3:0] SIG_OFDM_6    = 4'hB;
    localparam logic [3:0] SIG_OFDM_9    = 4'hF;
    localparam logic [3:0] SIG_OFDM_12   = 4'hA;
    localparam logic [3:0] SIG_OFDM_18   = 4'hE;
    localparam logic [3:0] SIG_OFDM_24   = 4'h9;
    localparam logic [3:0] SIG_OFDM_36   = 4'hD;
    localparam logic [3:0] SIG_OFDM_48   = 4'h8;
    localparam logic [3:0] SIG_OFDM_54   = 4'hC;

    // CCK SIGNAL bytes
    localparam logic [7:0] SIG_CCK_1     = 8'h0A;
    localparam logic [7:0] SIG_CCK_2     = 8'h14;
    localparam logic [7:0] SIG_CCK_5M5   = 8'h37;
    localparam logic [7:0] SIG_CCK_11    = 8'h6E;

    // SERVICE byte, plain and with the length-extension bit
    localparam logic [7:0] SERVICE_BASE  = 8'h04;
    localparam logic [7:0] SERVICE_LEXT  = 8'h84;

    // Division by eleven through a reciprocal: q = (x * RECIP_11) >> RECIP_SHIFT,
    // exact for every 16-bit x.
    localparam int unsigned RECIP_SHIFT  = 20;
    localparam logic [16:0] RECIP_11     = 17'd95326;
    localparam int unsigned X_W          = 16;
    localparam int unsigned PROD_W       = 33;
    localparam int unsigned Q_W          = PROD_W - RECIP_SHIFT;

    typedef enum logic [1:0] {
        KIND_OFDM,
        KIND_CCK,
        KIND_BAD
    } t_kind;

    typedef enum logic [1:0] {
        CCK_1M,
        CCK_2M,
        CCK_5M5,
        CCK_11M
    } t_cck;

    // After rate decode
    typedef struct packed {
        logic [11:0]    octets;
        t_kind          kind;
        t_cck           cck;
        logic [7:0]     code;
        logic [X_W-1:0] x;
    } t_dec;

    // After the reciprocal multiply
    typedef struct packed {
        t_dec           dec;
        logic [Q_W-1:0] q;
    } t_quo;

    // Finished result
    typedef struct packed {
        logic [31:0]    word;
        logic           err;
    } t_res;

endpackage

[design/wphg_decode.sv]
// First pipeline stage: decodes the rate code into kind and signal code and
// forms the dividend for the CCK duration. Depends on wphg_pkg.
module wphg_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [11:0]       i_octets,
    input  logic [7:0]        i_rate,
    output logic              o_valid,
    input  logic              i_ready,
    output wphg_pkg::t_dec    o_data
);
    import wphg_pkg::*;

    logic r_valid;
    t_dec r_data;
    t_dec n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data        = '0;
        n_data.octets = i_octets;
        n_data.kind   = KIND_BAD;
        n_data.cck    = CCK_1M;
        unique case (i_rate)
            RATE_OFDM_6: begin
                n_data.kind = KIND_OFDM; n_data.code = {4'd0, SIG_OFDM_6};
            end
            RATE_OFDM_9: begin
                n_data.kind = KIND_OFDM; n_data.code = {4'd0, SIG_OFDM_9};
            end
            RATE_OFDM_12: begin
                n_data.kind = KIND_OFDM; n_data.code = {4'd0, SIG_OFDM_12};
            end
            RATE_OFDM_18: begin
                n_data.kind = KIND_OFDM; n_data.code = {4'd0, SIG_OFDM_18};
            end
            RATE_OFDM_24: begin
                n_data.kind = KIND_OFDM; n_data.code = {4'd0, SIG_OFDM_24};
            end
            RATE_OFDM_36: begin
                n_data.kind = KIND_OFDM; n_data.code = {4'd0, SIG_OFDM_36};
            end
            RATE_OFDM_48: begin
                n_data.kind = KIND_OFDM; n_data.code = {4'd0, SIG_OFDM_48};
            end
            RATE_OFDM_54: begin
                n_data.kind = KIND_OFDM; n_data.code = {4'd0, SIG_OFDM_54};
            end
            RATE_CCK_1: begin
                n_data.kind = KIND_CCK; n_data.cck = CCK_1M; n_data.code = SIG_CCK_1;
            end
            RATE_CCK_2: begin
                n_data.kind = KIND_CCK; n_data.cck = CCK_2M; n_data.code = SIG_CCK_2;
            end
            RATE_CCK_5M5: begin
                n_data.kind = KIND_CCK; n_data.cck = CCK_5M5; n_data.code = SIG_CCK_5M5;
            end
            RATE_CCK_11: begin
                n_data.kind = KIND_CCK; n_data.cck = CCK_11M; n_data.code = SIG_CCK_11;
            end
            default: begin
                n_data.kind = KIND_BAD;
            end
        endcase
        // At 11 Mbit/s the duration is ceil(8n/11), at 5.5 Mbit/s ceil(16n/11).
        if (n_data.cck == CCK_11M) begin
            n_data.x = {1'b0, i_octets, 3'b000};
        end else begin
            n_data.x = {i_octets, 4'b0000};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[design/wphg_recip.sv]
// Second pipeline stage: divides the dividend by eleven with a reciprocal
// multiply and registers the quotient. Depends on wphg_pkg.
module wphg_recip (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  wphg_pkg::t_dec    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output wphg_pkg::t_quo    o_data
);
    import wphg_pkg::*;

    logic              r_valid;
    t_quo              r_data;
    logic [PROD_W-1:0] w_prod;

    assign o_ready = !r_valid || i_ready;
    assign w_prod  = PROD_W'(i_data.x) * PROD_W'(RECIP_11);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data.dec <= i_data;
            r_data.q   <= w_prod[PROD_W-1:RECIP_SHIFT];
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[design/wphg_assemble.sv]
// Third pipeline stage: rounds the duration up, picks the SERVICE byte and
// assembles the header word into the output register. Depends on wphg_pkg.
module wphg_assemble (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  wphg_pkg::t_quo    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output wphg_pkg::t_res    o_data
);
    import wphg_pkg::*;

    logic           r_valid;
    t_res           r_data;
    t_res           n_data;
    logic [15:0]    w_q;
    logic [15:0]    w_q11;
    logic [15:0]    w_diff;
    logic [3:0]     w_rem;
    logic           w_rem_nz;
    logic [15:0]    w_dur;
    logic [7:0]     w_service;

    assign o_ready  = !r_valid || i_ready;

    assign w_q      = 16'(i_data.q);
    assign w_q11    = (w_q << 3) + (w_q << 1) + w_q;
    assign w_diff   = i_data.dec.x - w_q11;
    assign w_rem    = w_diff[3:0];
    assign w_rem_nz = (w_rem != 4'd0);

    always_comb begin
        w_service = SERVICE_BASE;
        unique case (i_data.dec.cck)
            CCK_1M:  w_dur = {1'b0, i_data.dec.octets, 3'b000};
            CCK_2M:  w_dur = {2'b00, i_data.dec.octets, 2'b00};
            CCK_5M5: w_dur = w_q + 16'(w_rem_nz);
            CCK_11M: begin
                w_dur = w_q + 16'(w_rem_nz);
                if (w_rem_nz && (w_rem < 4'd4)) begin
                    w_service = SERVICE_LEXT;
                end
            end
            default: w_dur = '0;
        endcase

        n_data = '0;
        unique case (i_data.dec.kind)
            KIND_OFDM: n_data.word = {15'd0, i_data.dec.octets, 1'b0, i_data.dec.code[3:0]};
            KIND_CCK:  n_data.word = {w_dur, w_service, i_data.dec.code};
            KIND_BAD:  n_data.err  = 1'b1;
            default:   n_data.err  = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[design/wlan_plcp_header_generate.sv]
// Top level of the PLCP header generator: three register stages in a row.
// Depends on wphg_pkg, wphg_decode, wphg_recip and wphg_assemble.
//
//  Channel   Direction  Beat contents (lowest bit first)
//  s_axis    in         tdata: frame_octets[11:0], rate_code[19:12], zero pad [23:20]
//  m_axis    out        tdata: header_word[31:0]; tuser: rate_error
//
// Each request beat yields one result beat on m_axis; it passes through the three
// stages (rate decode, reciprocal multiply for the division by eleven, rounding and
// assembly) and is handed over when the output side is ready, and a new beat can be
// taken in every cycle while m_axis does not stall.
// Each stage takes a beat when empty or when its successor takes its contents, so a
// stall on m_axis fills the stages before s_axis_tready falls; reset clears valid bits.
module wlan_plcp_header_generate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // frame_octets[11:0], rate_code[19:12], pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // header_word[31:0]
    output logic        m_axis_tuser    // rate_error
);
    import wphg_pkg::*;

    logic  w_dec_valid;
    logic  w_dec_ready;
    t_dec  w_dec;
    logic  w_quo_valid;
    logic  w_quo_ready;
    t_quo  w_quo;
    t_res  w_res;

    // Stage one: classify the rate and form the dividend.
    wphg_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_octets (s_axis_tdata[11:0]),
        .i_rate   (s_axis_tdata[19:12]),
        .o_valid  (w_dec_valid),
        .i_ready  (w_dec_ready),
        .o_data   (w_dec)
    );

    // Stage two: quotient by eleven through the reciprocal.
    wphg_recip u_recip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_dec_valid),
        .o_ready  (w_dec_ready),
        .i_data   (w_dec),
        .o_valid  (w_quo_valid),
        .i_ready  (w_quo_ready),
        .o_data   (w_quo)
    );

    // Stage three: remainder, rounding, SERVICE byte and the output register.
    wphg_assemble u_assemble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_quo_valid),
        .o_ready  (w_quo_ready),
        .i_data   (w_quo),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (w_res)
    );

    assign m_axis_tdata = w_res.word;
    assign m_axis_tuser = w_res.err;

endmodule
